/* design/bmpf_pkg.sv */
// Shared constants, codes and types of the BMP pixel stream filter.
`timescale 1ns / 1ps
`default_nettype none

package bmpf_pkg;

    localparam int COUNT_BITS = 32;

    localparam logic [5:0] HEADER_BYTES = 6'd54;
    localparam logic [5:0] WIDTH_FIRST  = 6'd18;
    localparam logic [5:0] WIDTH_LAST   = 6'd21;

    localparam logic [1:0] MODE_NEGATIVE = 2'd0;
    localparam logic [1:0] MODE_GRAY     = 2'd1;
    localparam logic [1:0] MODE_SWAP     = 2'd2;

    localparam logic [1:0] RUN_ONE   = 2'd1;
    localparam logic [1:0] RUN_PIXEL = 2'd3;

    localparam logic [9:0] GRAY_RECIP = 10'd683;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] count;
    } bmpf_run_t;

endpackage

`default_nettype wire

/* design/bmpf_pixel_op.sv */
// Per-pixel transform: negative, grayscale average, channel rotation or pass-through.
`timescale 1ns / 1ps
`default_nettype none

module bmpf_pixel_op
    import bmpf_pkg::*;
(
    input  wire logic [1:0] mode,
    input  wire logic [7:0] first,
    input  wire logic [7:0] second,
    input  wire logic [7:0] third,
    output bmpf_run_t       run
);

    logic [9:0]  sum;
    logic [19:0] product;
    logic [7:0]  gray;

    // divide by three: multiply by 683 / 2048, exact for sums up to 765
    assign sum     = 10'(first) + 10'(second) + 10'(third);
    assign product = 20'(sum) * 20'(GRAY_RECIP);
    assign gray    = product[18:11];

    always_comb
    begin
        run.count = RUN_PIXEL;
        unique case (mode)
            MODE_NEGATIVE:
            begin
                run.b0 = ~first;
                run.b1 = ~second;
                run.b2 = ~third;
            end
            MODE_GRAY:
            begin
                run.b0 = gray;
                run.b1 = gray;
                run.b2 = gray;
            end
            MODE_SWAP:
            begin
                run.b0 = second;
                run.b1 = third;
                run.b2 = first;
            end
            default:
            begin
                run.b0 = first;
                run.b1 = second;
                run.b2 = third;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/bmpf_out_queue.sv */
// Output register: holds one run of one or three bytes and drains it a beat at a time.
`timescale 1ns / 1ps
`default_nettype none

module bmpf_out_queue
    import bmpf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       load,
    input  wire bmpf_run_t  run,
    output logic            load_ok,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      byte_out,
    output logic            last_of_run
);

    bmpf_run_t  run_reg;
    logic [1:0] idx_reg;
    logic       valid_reg;
    logic       out_fire;

    assign out_valid   = valid_reg;
    assign out_fire    = valid_reg && !out_stall;
    assign last_of_run = (idx_reg == (run_reg.count - 2'd1));
    assign load_ok     = !valid_reg || (out_fire && last_of_run);

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    byte_out = run_reg.b0;
            2'd1:    byte_out = run_reg.b1;
            2'd2:    byte_out = run_reg.b2;
            default: byte_out = run_reg.b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            if (last_of_run)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            run_reg <= run;
        end
    end

endmodule

`default_nettype wire

/* design/bmp_pixel_stream_filter.sv */
// Top level of the BMP pixel stream filter: header and row parser, pixel transform, output.
// A result-producing byte shows its first output beat in the cycle after it is accepted.
// Throughput: one byte per cycle when not stalled; pixel bytes completing no pixel never stall.
// A completed pixel drains three beats from the output register, one per cycle while
// out_stall is low, which sets the sustained rate at one output beat per cycle.
// Reset: rst_n clears all counters, the width, the output register's valid flag and mode (negative).
`timescale 1ns / 1ps
`default_nettype none

module bmp_pixel_stream_filter
    import bmpf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] mode,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] byte_in,
    input  wire logic       file_start,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      byte_out,
    output logic            last_of_run
);

    logic [1:0]            mode_reg;
    logic [5:0]            header_count_reg, header_count_next;
    logic [COUNT_BITS-1:0] row_width_reg, row_width_next;
    logic [COUNT_BITS-1:0] pixel_count_reg, pixel_count_next;
    logic [1:0]            sub_index_reg, sub_index_next;
    logic [1:0]            pad_count_reg, pad_count_next;
    logic                  in_padding_reg, in_padding_next;
    logic [7:0]            held_first_reg, held_first_next;
    logic [7:0]            held_second_reg, held_second_next;

    logic [5:0]            hc;
    logic [COUNT_BITS-1:0] rw;
    logic [COUNT_BITS-1:0] pc;
    logic [COUNT_BITS-1:0] pc_inc;
    logic [1:0]            sub;
    logic [1:0]            padc;
    logic [1:0]            padc_inc;
    logic                  pad;
    logic [7:0]            h1;
    logic [7:0]            h2;
    logic [31:0]           width_full;
    logic [1:0]            lane;

    logic                  need_out;
    logic                  pixel_done;
    logic                  in_fire;
    logic                  load_ok;
    bmpf_run_t             pixel_run;
    bmpf_run_t             run;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NEGATIVE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg <= mode;
        end
    end

    // clear the stream state first when a new file opens
    always_comb
    begin
        hc   = file_start ? 6'd0 : header_count_reg;
        rw   = file_start ? '0 : row_width_reg;
        pc   = file_start ? '0 : pixel_count_reg;
        sub  = file_start ? 2'd0 : sub_index_reg;
        padc = file_start ? 2'd0 : pad_count_reg;
        pad  = file_start ? 1'b0 : in_padding_reg;
        h1   = file_start ? 8'd0 : held_first_reg;
        h2   = file_start ? 8'd0 : held_second_reg;

        pc_inc     = pc + COUNT_BITS'(1);
        padc_inc   = padc + 2'd1;
        lane       = 2'(hc - WIDTH_FIRST);
        width_full = 32'(rw);
        width_full[{lane, 3'b000} +: 8] = byte_in;

        header_count_next = hc;
        row_width_next    = rw;
        pixel_count_next  = pc;
        sub_index_next    = sub;
        pad_count_next    = padc;
        in_padding_next   = pad;
        held_first_next   = h1;
        held_second_next  = h2;
        need_out          = 1'b1;
        pixel_done        = 1'b0;

        priority if (hc < HEADER_BYTES)
        begin
            if (hc >= WIDTH_FIRST && hc <= WIDTH_LAST)
            begin
                row_width_next = width_full[COUNT_BITS-1:0];
            end
            header_count_next = hc + 6'd1;
        end
        else if (rw == '0)
        begin
            need_out = 1'b1;
        end
        else if (pad)
        begin
            if (padc_inc >= rw[1:0])
            begin
                pad_count_next  = 2'd0;
                in_padding_next = 1'b0;
            end
            else
            begin
                pad_count_next = padc_inc;
            end
        end
        else if (sub == 2'd0)
        begin
            held_first_next = byte_in;
            sub_index_next  = 2'd1;
            need_out        = 1'b0;
        end
        else if (sub == 2'd1)
        begin
            held_second_next = byte_in;
            sub_index_next   = 2'd2;
            need_out         = 1'b0;
        end
        else
        begin
            pixel_done     = 1'b1;
            sub_index_next = 2'd0;
            if (pc_inc >= rw)
            begin
                pixel_count_next = '0;
                pad_count_next   = 2'd0;
                in_padding_next  = (rw[1:0] != 2'd0);
            end
            else
            begin
                pixel_count_next = pc_inc;
            end
        end
    end

    bmpf_pixel_op u_pixel_op
    (
        .mode   (mode_reg),
        .first  (h1),
        .second (h2),
        .third  (byte_in),
        .run    (pixel_run)
    );

    always_comb
    begin
        if (pixel_done)
        begin
            run = pixel_run;
        end
        else
        begin
            run.b0    = byte_in;
            run.b1    = byte_in;
            run.b2    = byte_in;
            run.count = RUN_ONE;
        end
    end

    // pixel bytes that complete nothing pass even while the output register is full
    assign in_stall = need_out && !load_ok;
    assign in_fire  = in_valid && !in_stall;

    bmpf_out_queue u_out_queue
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (in_fire && need_out),
        .run         (run),
        .load_ok     (load_ok),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .byte_out    (byte_out),
        .last_of_run (last_of_run)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_count_reg <= 6'd0;
            row_width_reg    <= '0;
            pixel_count_reg  <= '0;
            sub_index_reg    <= 2'd0;
            pad_count_reg    <= 2'd0;
            in_padding_reg   <= 1'b0;
        end
        else if (in_fire)
        begin
            header_count_reg <= header_count_next;
            row_width_reg    <= row_width_next;
            pixel_count_reg  <= pixel_count_next;
            sub_index_reg    <= sub_index_next;
            pad_count_reg    <= pad_count_next;
            in_padding_reg   <= in_padding_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            held_first_reg  <= held_first_next;
            held_second_reg <= held_second_next;
        end
    end

    a_sub_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        sub_index_reg != 2'd3)
        else $error("pixel byte index out of range");

    a_header_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        header_count_reg <= HEADER_BYTES)
        else $error("header count past header length");

    a_pad_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_padding_reg |-> pad_count_reg == 2'd0)
        else $error("padding count nonzero outside padding");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && need_out |=> out_valid)
        else $error("accepted byte produced no output beat");

    a_no_result_mid_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !need_out |-> sub_index_next != 2'd0)
        else $error("silent byte did not advance pixel assembly");

endmodule

`default_nettype wire

/* tb/bmp_pixel_stream_filter_tb.sv */
// Self-checking testbench for the BMP pixel stream filter: directed files, random streams, stalls.
`timescale 1ns / 1ps

module bmp_pixel_stream_filter_tb;
    import bmpf_pkg::*;

    localparam logic [1:0]  MODE_PASS   = 2'd3;
    localparam logic [31:0] WIDTH_MASK  = 32'((64'd1 << COUNT_BITS) - 64'd1);
    localparam int          HOLD_CYCLES = 80;
    localparam int          SETTLE      = 4;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } beat_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_mode;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] byte_in;
    logic       file_start;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] byte_out;
    logic       last_of_run;

    beat_t      pending_beats[$];
    int         errors = 0;
    int         send_idle_pct = 0;
    int         stall_pct = 0;
    logic       hold_req = 1'b0;
    logic       rx_hold = 1'b0;

    logic [1:0]  filt_mode;
    logic [5:0]  hdr_cnt;
    logic [31:0] row_width;
    logic [31:0] pix_cnt;
    logic [1:0]  sub_idx;
    logic [1:0]  pad_cnt;
    logic        in_pad;
    logic [7:0]  held0;
    logic [7:0]  held1;

    bmp_pixel_stream_filter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .mode       (cfg_mode),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .byte_in    (byte_in),
        .file_start (file_start),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .byte_out   (byte_out),
        .last_of_run(last_of_run)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic clear_file_state();
        hdr_cnt   = '0;
        row_width = '0;
        pix_cnt   = '0;
        sub_idx   = '0;
        pad_cnt   = '0;
        in_pad    = 1'b0;
        held0     = '0;
        held1     = '0;
    endtask

    task automatic push_beat(input logic [7:0] d, input logic l);
        beat_t bt;
        bt.data = d;
        bt.last = l;
        pending_beats.push_back(bt);
    endtask

    task automatic predict_filter(input logic [7:0] b, input logic fs);
        logic [5:0] k;
        logic [4:0] sh;
        logic [9:0] sum;
        logic [7:0] r0, r1, r2;
        logic [1:0] pad_size;
        if (fs)
            clear_file_state();
        if (hdr_cnt < HEADER_BYTES)
        begin
            if (hdr_cnt >= WIDTH_FIRST && hdr_cnt <= WIDTH_LAST)
            begin
                k  = hdr_cnt - WIDTH_FIRST;
                sh = {k[1:0], 3'b000};
                row_width = (row_width & ~(32'hFF << sh)) | (32'(b) << sh);
                row_width = row_width & WIDTH_MASK;
            end
            hdr_cnt = hdr_cnt + 6'd1;
            push_beat(b, 1'b1);
        end
        else if (row_width == '0)
            push_beat(b, 1'b1);
        else if (in_pad)
        begin
            pad_size = row_width[1:0];
            pad_cnt  = pad_cnt + 2'd1;
            if (pad_cnt >= pad_size)
            begin
                pad_cnt = '0;
                in_pad  = 1'b0;
            end
            push_beat(b, 1'b1);
        end
        else if (sub_idx == 2'd0)
        begin
            held0   = b;
            sub_idx = 2'd1;
        end
        else if (sub_idx == 2'd1)
        begin
            held1   = b;
            sub_idx = 2'd2;
        end
        else
        begin
            pad_size = row_width[1:0];
            sub_idx  = 2'd0;
            case (filt_mode)
                MODE_NEGATIVE:
                begin
                    r0 = ~held0;
                    r1 = ~held1;
                    r2 = ~b;
                end
                MODE_GRAY:
                begin
                    sum = 10'(held0) + 10'(held1) + 10'(b);
                    r0  = 8'(sum / 10'd3);
                    r1  = r0;
                    r2  = r0;
                end
                MODE_SWAP:
                begin
                    r0 = held1;
                    r1 = b;
                    r2 = held0;
                end
                default:
                begin
                    r0 = held0;
                    r1 = held1;
                    r2 = b;
                end
            endcase
            pix_cnt = (pix_cnt + 32'd1) & WIDTH_MASK;
            if (pix_cnt >= row_width)
            begin
                pix_cnt = '0;
                pad_cnt = '0;
                in_pad  = (pad_size != 2'd0);
            end
            push_beat(r0, 1'b0);
            push_beat(r1, 1'b0);
            push_beat(r2, 1'b1);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fs);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid   <= 1'b1;
        byte_in    <= b;
        file_start <= fs;
        do
            @(posedge clk);
        while (in_stall);
        predict_filter(b, fs);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_beats.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_mode  <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        filt_mode = m;
    endtask

    task automatic set_phase(input int idle, input int stall);
        send_idle_pct = idle;
        stall_pct     = stall;
    endtask

    task automatic send_header(input logic [31:0] w);
        logic [7:0] b;
        for (int i = 0; i < HEADER_BYTES; i++)
        begin
            b = 8'($urandom_range(255));
            if (i >= WIDTH_FIRST && i <= WIDTH_LAST)
                b = w[8 * (i - WIDTH_FIRST) +: 8];
            send_byte(b, i == 0);
        end
    endtask

    task automatic send_pixel(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2);
        send_byte(b0, 1'b0);
        send_byte(b1, 1'b0);
        send_byte(b2, 1'b0);
    endtask

    task automatic send_pad(input logic [31:0] w);
        for (int i = 0; i < int'(w[1:0]); i++)
            send_byte(8'($urandom_range(255)), 1'b0);
    endtask

    task automatic send_rows(input logic [31:0] w, input int rows);
        for (int r = 0; r < rows; r++)
        begin
            for (int p = 0; p < int'(w); p++)
                send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                           8'($urandom_range(255)));
            send_pad(w);
        end
    endtask

    task automatic test_negative();
        set_phase(0, 0);
        write_mode(MODE_NEGATIVE);
        send_header(32'd1);
        send_pixel(8'h00, 8'hFF, 8'h5A);
        send_pad(32'd1);
    endtask

    task automatic test_gray();
        write_mode(MODE_GRAY);
        send_pixel(8'hFF, 8'hFE, 8'hFF);
        send_pad(32'd1);
        send_pixel(8'h80, 8'h7F, 8'hAA);
        send_pad(32'd1);
    endtask

    task automatic test_swap();
        write_mode(MODE_SWAP);
        send_pixel(8'h01, 8'h02, 8'h03);
        send_pad(32'd1);
    endtask

    task automatic test_unused_mode();
        write_mode(MODE_PASS);
        send_rows(32'd1, 1);
    endtask

    task automatic test_long_hold();
        set_phase(0, 0);
        write_mode(MODE_SWAP);
        hold_req = 1'b1;
        send_rows(32'd1, 2);
    endtask

    task automatic test_drain_pause();
        set_phase(33, 33);
        write_mode(MODE_GRAY);
        send_pixel(8'h10, 8'h20, 8'h30);
        wait_drained();
        send_pad(32'd1);
        send_byte(8'h40, 1'b0);
        send_byte(8'h50, 1'b0);
        wait_drained();
        send_byte(8'h60, 1'b0);
        send_pad(32'd1);
    endtask

    task automatic test_partial_pixel();
        send_byte(8'h78, 1'b0);
        send_byte(8'h9A, 1'b0);
    endtask

    task automatic test_zero_width();
        send_header(32'd0);
        for (int i = 0; i < 3; i++)
            send_byte(8'($urandom_range(255)), 1'b0);
    endtask

    task automatic test_wide_width();
        write_mode(MODE_NEGATIVE);
        send_header(32'hFFFF_FFFF);
        send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)));
    endtask

    task automatic test_random();
        int idle_tab[4]  = '{0, 73, 0, 33};
        int stall_tab[4] = '{0, 0, 73, 33};
        for (int ph = 0; ph < 4; ph++)
        begin
            set_phase(idle_tab[ph], stall_tab[ph]);
            write_mode(2'($urandom_range(3)));
            for (int i = 0; i < 4; i++)
                send_byte(8'($urandom_range(255)), 1'b0);
        end
    endtask

    initial
    begin
        cfg_valid  = 1'b0;
        cfg_mode   = MODE_NEGATIVE;
        in_valid   = 1'b0;
        byte_in    = 8'h00;
        file_start = 1'b0;
        filt_mode  = MODE_NEGATIVE;
        clear_file_state();
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_negative();
        test_gray();
        test_swap();
        test_unused_mode();
        test_long_hold();
        test_drain_pause();
        test_partial_pixel();
        test_zero_width();
        test_wide_width();
        test_random();
        write_mode(MODE_PASS);
        write_mode(MODE_NEGATIVE);

        wait_drained();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        forever
        begin
            wait (hold_req);
            @(posedge clk);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold <= 1'b0;
            hold_req = 1'b0;
        end
    end

    task automatic check_beat(input logic [7:0] d, input logic l);
        beat_t bt;
        if (pending_beats.size() == 0)
        begin
            errors++;
            if (errors <= 100)
                $display("%0t: unexpected beat, expected none, actual byte_out=%h last_of_run=%b",
                         $time, d, l);
        end
        else
        begin
            bt = pending_beats.pop_front();
            if (bt.data !== d || bt.last !== l)
            begin
                errors++;
                if (errors <= 100)
                    $display("%0t: expected byte_out=%h last_of_run=%b, actual byte_out=%h last_of_run=%b",
                             $time, bt.data, bt.last, d, l);
            end
        end
    endtask

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                check_beat(byte_out, last_of_run);
            out_stall <= rx_hold || ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
